### sv/can_bts_pkg.sv
`default_nettype none
package can_bts_pkg;

  localparam int unsigned BaudW  = 20;
  localparam int unsigned ClkW   = 32;
  localparam int unsigned ProdW  = 14;
  localparam int unsigned BaseW  = 10;

  localparam logic [ClkW-1:0]  CLK_RATE_RST = 32'd48000000;
  localparam logic [3:0]       DIV_MAX      = 4'd15;
  localparam logic [4:0]       PRESC_M1_MAX = 5'd31;
  localparam logic [4:0]       SEG_MIN      = 5'd3;
  localparam logic [4:0]       SEG_MAX      = 5'd17;
  localparam logic [2:0]       SJW_MAX      = 3'd3;
  localparam logic [ProdW-1:0] CPB_MAX      = 14'd8704;
  localparam logic [4:0]       DIV_STEP_LAST = 5'd31;

  typedef struct packed {
    logic load;
    logic div_step;
    logic search_init;
    logic search_step;
    logic hit;
    logic load_out;
  } can_bts_cmd_t;

  typedef struct packed {
    logic baud_zero;
    logic div_last;
    logic out_of_range;
    logic match;
    logic search_last;
  } can_bts_status_t;

endpackage
`default_nettype wire

### sv/can_bts_ctrl.sv
`default_nettype none
module can_bts_ctrl (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  input  can_bts_pkg::can_bts_status_t sts,
  output can_bts_pkg::can_bts_cmd_t    cmd
);
  import can_bts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_INIT,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_free   = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    cmd            = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.baud_zero) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.div_step = 1'b1;
          if (sts.div_last) state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.search_init = 1'b1;
        state_nxt       = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (sts.out_of_range) begin
          state_nxt = ST_FINISH;
        end else if (sts.match) begin
          cmd.hit   = 1'b1;
          state_nxt = ST_FINISH;
        end else if (sts.search_last) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      ST_FINISH: begin
        // hold the result until the output register is free
        if (out_free) begin
          cmd.load_out   = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/can_bts_dp.sv
`default_nettype none
module can_bts_dp (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_wr_en,
  input  wire  [can_bts_pkg::ClkW-1:0]         cfg_wr_data,
  input  wire  [can_bts_pkg::BaudW-1:0]        bit_rate,
  input  can_bts_pkg::can_bts_cmd_t            cmd,
  output can_bts_pkg::can_bts_status_t         sts,
  output logic                                 found,
  output logic [3:0]                           prescaler_div,
  output logic [14:0]                          timing_word
);
  import can_bts_pkg::*;

  logic [ClkW-1:0]  clock_rate_r;
  logic [BaudW-1:0] baud_r;
  logic [BaudW-1:0] rem_r, rem_nxt;
  logic [ClkW-1:0]  quo_r, quo_nxt;
  logic [4:0]       cnt_r;
  logic [BaudW:0]   rem_sh;
  logic [BaudW:0]   rem_sub;
  logic             q_bit;

  logic [3:0]       dv_r, dv_nxt;
  logic [4:0]       prm1_r, prm1_nxt;
  logic [4:0]       sg_r, sg_nxt;
  logic [BaseW-1:0] base_r, base_nxt;
  logic [ProdW-1:0] prod_r, prod_nxt;
  logic             found_r;

  logic             out_found_r;
  logic [3:0]       out_div_r;
  logic [14:0]      out_word_r;

  logic [3:0]       rest;
  logic [2:0]       s1;
  logic [2:0]       s2;
  logic [1:0]       sjw;
  logic [14:0]      word;

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem_r, quo_r[ClkW-1]};
  assign rem_sub = rem_sh - {1'b0, baud_r};
  assign q_bit   = (rem_sh >= {1'b0, baud_r});
  assign rem_nxt = q_bit ? rem_sub[BaudW-1:0] : rem_sh[BaudW-1:0];
  assign quo_nxt = {quo_r[ClkW-2:0], q_bit};

  assign sts.baud_zero    = (baud_r == '0);
  assign sts.div_last     = (cnt_r == DIV_STEP_LAST);
  assign sts.out_of_range = (quo_r == '0) || (quo_r > {{(ClkW-ProdW){1'b0}}, CPB_MAX});
  assign sts.match        = (quo_r[ProdW-1:0] == prod_r);
  assign sts.search_last  = (dv_r == DIV_MAX) && (prm1_r == PRESC_M1_MAX) && (sg_r == SEG_MAX);

  // walk segments fastest, then prescaler, then divider; product kept by adds
  always_comb begin
    dv_nxt   = dv_r;
    prm1_nxt = prm1_r;
    sg_nxt   = sg_r;
    base_nxt = base_r;
    prod_nxt = prod_r + {{(ProdW-BaseW){1'b0}}, base_r};
    if (sg_r == SEG_MAX) begin
      sg_nxt = SEG_MIN;
      if (prm1_r == PRESC_M1_MAX) begin
        prm1_nxt = '0;
        dv_nxt   = dv_r + 4'd1;
        base_nxt = {{(BaseW-4){1'b0}}, dv_r} + BaseW'(2);
      end else begin
        prm1_nxt = prm1_r + 5'd1;
        base_nxt = base_r + {{(BaseW-4){1'b0}}, dv_r} + BaseW'(1);
      end
      prod_nxt = {{(ProdW-BaseW){1'b0}}, base_nxt}
               + {{(ProdW-BaseW-1){1'b0}}, base_nxt, 1'b0};
    end else begin
      sg_nxt = sg_r + 5'd1;
    end
  end

  // split segments and pack the timing word
  always_comb begin
    rest = 4'(sg_r - SEG_MIN);
    s1   = rest[3:1];
    s2   = 3'(rest - {1'b0, s1});
    sjw  = ({1'b0, s1} > {1'b0, SJW_MAX}) ? SJW_MAX[1:0] : s1[1:0];
    word = {s2, 1'b0, s1, sjw, 1'b0, prm1_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_rate_r <= CLK_RATE_RST;
    end else if (cfg_wr_en) begin
      clock_rate_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      baud_r  <= bit_rate;
      rem_r   <= '0;
      quo_r   <= clock_rate_r;
      cnt_r   <= '0;
      found_r <= 1'b0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r + 5'd1;
    end
    if (cmd.search_init) begin
      dv_r   <= '0;
      prm1_r <= '0;
      sg_r   <= SEG_MIN;
      base_r <= BaseW'(1);
      prod_r <= ProdW'(3);
    end
    if (cmd.search_step) begin
      dv_r   <= dv_nxt;
      prm1_r <= prm1_nxt;
      sg_r   <= sg_nxt;
      base_r <= base_nxt;
      prod_r <= prod_nxt;
    end
    if (cmd.hit) found_r <= 1'b1;
    if (cmd.load_out) begin
      out_found_r <= found_r;
      out_div_r   <= found_r ? dv_r : 4'd0;
      out_word_r  <= found_r ? word : 15'd0;
    end
  end

  assign found         = out_found_r;
  assign prescaler_div = out_div_r;
  assign timing_word   = out_word_r;

endmodule
`default_nettype wire

### sv/can_bit_timing_search.sv
// CAN bit timing search: clock rate / bit rate, then first exact divider/prescaler/segment fit.
// Sequence: load, 32-step division, search setup, search over up to 7680 triples, finish.
// A zero bit rate skips division and search; a clocks-per-bit outside 1..8704 skips the search.
// One request at a time: a new one is taken only in idle, after the last result has gone into the
// output register (which may still wait for out_tready); the search tests one triple per cycle.
// Reset (rst_n low, synchronous) returns control to idle and clock_rate to 48000000.
`default_nettype none
module can_bit_timing_search (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [31:0] cfg_wr_data,   // clock_rate
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,      // [19:0] bit_rate, [23:20] zero
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata      // [0] found, [4:1] prescaler_div, [19:5] timing_word
);
  import can_bts_pkg::*;

  can_bts_cmd_t    cmd;
  can_bts_status_t sts;
  logic            found;
  logic [3:0]      prescaler_div;
  logic [14:0]     timing_word;

  can_bts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  can_bts_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .bit_rate      (in_tdata[BaudW-1:0]),
    .cmd           (cmd),
    .sts           (sts),
    .found         (found),
    .prescaler_div (prescaler_div),
    .timing_word   (timing_word)
  );

  assign out_tdata = {4'd0, timing_word, prescaler_div, found};

endmodule
`default_nettype wire
